>>> design/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types and codes for the pid tagged translation buffer
// ----------------------------------------------------------------------------
package ptl_pkg;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_LOOKUP     = 3'd0;
    localparam logic [2:0] KIND_INSERT     = 3'd1;
    localparam logic [2:0] KIND_INV_ENTRY  = 3'd2;
    localparam logic [2:0] KIND_INV_PID    = 3'd3;
    localparam logic [2:0] KIND_INV_FRAME  = 3'd4;
    localparam logic [2:0] KIND_CLEAR_STAT = 3'd5;

    // compare modes of the entry unit
    localparam logic [1:0] MATCH_TAG   = 2'd0;
    localparam logic [1:0] MATCH_PID   = 2'd1;
    localparam logic [1:0] MATCH_FRAME = 2'd2;

    // rank update operations
    localparam logic UPD_PROMOTE = 1'b0;
    localparam logic UPD_DROP    = 1'b1;

    // fixed field widths of the channels
    localparam int PID_IN_W    = 8;
    localparam int PAGE_IN_W   = 20;
    localparam int FRAME_IN_W  = 20;
    localparam int FRAME_OUT_W = 20;
    localparam int CNT_W       = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [2:0]            kind;
        logic [PID_IN_W-1:0]   proc_id;
        logic [PAGE_IN_W-1:0]  page_num;
        logic [FRAME_IN_W-1:0] frame_in;
    } req_item_t;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame_out;
        logic                   evicted;
        logic [CNT_W-1:0]       hit_total;
        logic [CNT_W-1:0]       miss_total;
        logic [CNT_W-1:0]       evict_total;
    } rsp_item_t;

    // control of the shared entry unit
    typedef struct packed {
        logic [1:0] match_mode;
        logic       upd_op;
    } alu_ctl_t;

    // flags from the shared entry unit
    typedef struct packed {
        logic match;
        logic oldest;
    } alu_res_t;

endpackage

>>> design/ptl_entry_ram.sv
// ----------------------------------------------------------------------------
// ptl_entry_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ptl_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 52
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/ptl_entry_alu.sv
// ----------------------------------------------------------------------------
// ptl_entry_alu
// shared per-entry unit: tag, pid or frame compare, oldest check and rank adjust
// ----------------------------------------------------------------------------
module ptl_entry_alu #(
    parameter int ENTRIES     = 16,
    parameter int PID_WIDTH   = 8,
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 20
) (
    input  ptl_pkg::alu_ctl_t              ctl,
    input  logic                           ent_valid,
    input  logic [PID_WIDTH-1:0]           ent_pid,
    input  logic [PAGE_WIDTH-1:0]          ent_page,
    input  logic [FRAME_WIDTH-1:0]         ent_frame,
    input  logic [$clog2(ENTRIES)-1:0]     ent_rank,
    input  logic [PID_WIDTH-1:0]           key_pid,
    input  logic [PAGE_WIDTH-1:0]          key_page,
    input  logic [FRAME_WIDTH-1:0]         key_frame,
    input  logic                           is_target,
    input  logic [$clog2(ENTRIES)-1:0]     tgt_rank,
    output ptl_pkg::alu_res_t              res,
    output logic [$clog2(ENTRIES)-1:0]     new_rank
);
    import ptl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(ENTRIES - 1);

    logic pid_eq;
    logic page_eq;
    logic frame_eq;
    logic rank_lt;
    logic rank_gt;

    assign pid_eq   = (ent_pid == key_pid);
    assign page_eq  = (ent_page == key_page);
    assign frame_eq = (ent_frame == key_frame);
    assign rank_lt  = (ent_rank < tgt_rank);
    assign rank_gt  = (ent_rank > tgt_rank);

    // match against the key under the selected mode
    always_comb
    begin
        res.match = 1'b0;
        case (ctl.match_mode)
            MATCH_TAG:   res.match = ent_valid && pid_eq && page_eq;
            MATCH_PID:   res.match = ent_valid && pid_eq;
            MATCH_FRAME: res.match = ent_valid && frame_eq;
            default:     res.match = 1'b0;
        endcase
        res.oldest = ent_valid && (ent_rank == LAST_RANK);
    end

    // rank after promotion or removal of the target
    always_comb
    begin
        new_rank = ent_rank;
        if (ctl.upd_op == UPD_PROMOTE)
        begin
            if (is_target)
            begin
                new_rank = '0;
            end
            else if (ent_valid && rank_lt)
            begin
                new_rank = ent_rank + 1'b1;
            end
        end
        else
        begin
            if (!is_target && ent_valid && rank_gt)
            begin
                new_rank = ent_rank - 1'b1;
            end
        end
    end

endmodule

>>> design/pid_tagged_tlb_lru.sv
// ----------------------------------------------------------------------------
// pid_tagged_tlb_lru
// fully associative translation buffer with process id tags and lru ranks
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_ready / req_item) carries one operation:
//   lookup, insert, invalidate entry, invalidate pid, invalidate frame or
//   clear statistics. rsp channel (rsp_valid / rsp_ready / rsp_item) returns
//   one result per request with the hit flag, frame, evicted flag and the
//   three saturating counters after the operation.
//   every operation but clear statistics walks the entry store one entry per
//   cycle through one shared compare and rank unit: a match pass, a decision
//   step, and for hits, inserts and removals an update pass; a clear goes
//   straight to the decision step. invalidate by pid or frame repeats match
//   and update once per removed entry and ends with one more match pass.
//   req_ready is high only while no operation is in progress.
//   a finished result sits in an output register; the next request is
//   taken while it waits. a stalled receiver holds the block in its last
//   step until the output register frees.
//   reset empties the buffer through per-entry valid bits and clears the
//   counters; the entry store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module pid_tagged_tlb_lru #(
    parameter int ENTRIES     = 16,
    parameter int PID_WIDTH   = 8,
    parameter int PAGE_WIDTH  = 20,
    parameter int FRAME_WIDTH = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ptl_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ptl_pkg::rsp_item_t rsp_item
);
    import ptl_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = PID_WIDTH + PAGE_WIDTH + FRAME_WIDTH + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MATCH  = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // control state
    logic [2:0]             state_reg, state_next;
    logic                   issue_reg, issue_next;
    logic                   dval_reg, dval_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic                   found_reg, found_next;
    logic                   free_found_reg, free_found_next;
    logic                   victim_found_reg, victim_found_next;
    logic [CNT_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]       evict_cnt_reg, evict_cnt_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    // operation payload
    req_item_t              item_reg, item_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       didx_reg, didx_next;
    logic [IDX_W-1:0]       tgt_reg, tgt_next;
    logic [IDX_W-1:0]       tgt_rank_reg, tgt_rank_next;
    logic [FRAME_WIDTH-1:0] tgt_frame_reg, tgt_frame_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;
    logic                   upd_op_reg, upd_op_next;
    logic                   wr_tags_reg, wr_tags_next;
    logic                   wr_frame_reg, wr_frame_next;
    logic                   hit_flag_reg, hit_flag_next;
    logic [FRAME_OUT_W-1:0] fout_reg, fout_next;
    logic                   ev_reg, ev_next;
    rsp_item_t              rsp_item_reg, rsp_item_next;

    // key fields fitted to the stored widths
    logic [31:0]            pid_ext;
    logic [31:0]            page_ext;
    logic [31:0]            frame_ext;
    logic [31:0]            tgt_frame_ext;
    logic [PID_WIDTH-1:0]   key_pid;
    logic [PAGE_WIDTH-1:0]  key_page;
    logic [FRAME_WIDTH-1:0] key_frame;

    assign pid_ext       = 32'(item_reg.proc_id);
    assign page_ext      = 32'(item_reg.page_num);
    assign frame_ext     = 32'(item_reg.frame_in);
    assign tgt_frame_ext = 32'(tgt_frame_reg);
    assign key_pid       = pid_ext[PID_WIDTH-1:0];
    assign key_page      = page_ext[PAGE_WIDTH-1:0];
    assign key_frame     = frame_ext[FRAME_WIDTH-1:0];

    // entry store
    logic                   wr_en;
    logic [WORD_W-1:0]      wr_word;
    logic [WORD_W-1:0]      rd_word;

    ptl_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (issue_reg),
        .rd_addr (idx_reg),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (didx_reg),
        .wr_data (wr_word)
    );

    // fields of the entry in the data stage
    logic [PID_WIDTH-1:0]   ent_pid;
    logic [PAGE_WIDTH-1:0]  ent_page;
    logic [FRAME_WIDTH-1:0] ent_frame;
    logic [IDX_W-1:0]       ent_rank;
    logic                   ent_valid;
    logic                   is_target;

    assign ent_pid   = rd_word[WORD_W-1 -: PID_WIDTH];
    assign ent_page  = rd_word[IDX_W+FRAME_WIDTH +: PAGE_WIDTH];
    assign ent_frame = rd_word[IDX_W +: FRAME_WIDTH];
    assign ent_rank  = rd_word[IDX_W-1:0];
    assign ent_valid = valid_reg[didx_reg];
    assign is_target = (didx_reg == tgt_reg);

    // shared compare and rank unit
    alu_ctl_t               alu_ctl;
    alu_res_t               alu_res;
    logic [IDX_W-1:0]       new_rank;

    always_comb
    begin
        alu_ctl.upd_op = upd_op_reg;
        case (item_reg.kind) inside
            KIND_INV_PID:   alu_ctl.match_mode = MATCH_PID;
            KIND_INV_FRAME: alu_ctl.match_mode = MATCH_FRAME;
            default:        alu_ctl.match_mode = MATCH_TAG;
        endcase
    end

    ptl_entry_alu #(
        .ENTRIES     (ENTRIES),
        .PID_WIDTH   (PID_WIDTH),
        .PAGE_WIDTH  (PAGE_WIDTH),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_alu (
        .ctl       (alu_ctl),
        .ent_valid (ent_valid),
        .ent_pid   (ent_pid),
        .ent_page  (ent_page),
        .ent_frame (ent_frame),
        .ent_rank  (ent_rank),
        .key_pid   (key_pid),
        .key_page  (key_page),
        .key_frame (key_frame),
        .is_target (is_target),
        .tgt_rank  (tgt_rank_reg),
        .res       (alu_res),
        .new_rank  (new_rank)
    );

    // write-back word of the update pass
    logic                   take_tags;
    logic                   take_frame;

    assign take_tags  = is_target && wr_tags_reg;
    assign take_frame = is_target && (wr_tags_reg || wr_frame_reg);
    assign wr_en      = (state_reg == ST_UPDATE) && dval_reg;
    assign wr_word    = {take_tags ? key_pid : ent_pid,
                         take_tags ? key_page : ent_page,
                         take_frame ? key_frame : ent_frame,
                         new_rank};

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        issue_next        = issue_reg;
        idx_next          = idx_reg;
        dval_next         = issue_reg;
        didx_next         = idx_reg;
        valid_next        = valid_reg;
        found_next        = found_reg;
        free_found_next   = free_found_reg;
        victim_found_next = victim_found_reg;
        hit_cnt_next      = hit_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        evict_cnt_next    = evict_cnt_reg;
        rsp_valid_next    = rsp_valid_reg;
        item_next         = item_reg;
        tgt_next          = tgt_reg;
        tgt_rank_next     = tgt_rank_reg;
        tgt_frame_next    = tgt_frame_reg;
        free_idx_next     = free_idx_reg;
        victim_next       = victim_reg;
        upd_op_next       = upd_op_reg;
        wr_tags_next      = wr_tags_reg;
        wr_frame_next     = wr_frame_reg;
        hit_flag_next     = hit_flag_reg;
        fout_next         = fout_reg;
        ev_next           = ev_reg;
        rsp_item_next     = rsp_item_reg;

        // scan address walk
        if (issue_reg)
        begin
            if (idx_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        // output register drains on transfer
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next     = req_item;
                    hit_flag_next = 1'b0;
                    fout_next     = '0;
                    ev_next       = 1'b0;
                    wr_tags_next  = 1'b0;
                    wr_frame_next = 1'b0;
                    case (req_item.kind) inside
                        KIND_LOOKUP, KIND_INSERT, KIND_INV_ENTRY,
                        KIND_INV_PID, KIND_INV_FRAME:
                        begin
                            state_next        = ST_MATCH;
                            issue_next        = 1'b1;
                            idx_next          = '0;
                            found_next        = 1'b0;
                            free_found_next   = 1'b0;
                            victim_found_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_DECIDE;
                        end
                    endcase
                end
            end

            ST_MATCH:
            begin
                if (dval_reg)
                begin
                    if (alu_res.match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        tgt_next       = didx_reg;
                        tgt_rank_next  = ent_rank;
                        tgt_frame_next = ent_frame;
                    end
                    if (!ent_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = didx_reg;
                    end
                    if (alu_res.oldest)
                    begin
                        victim_found_next = 1'b1;
                        victim_next       = didx_reg;
                    end
                    if (didx_reg == LAST_IDX)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                state_next = ST_DONE;
                unique case (item_reg.kind) inside
                    KIND_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            hit_flag_next = 1'b1;
                            fout_next     = tgt_frame_ext[FRAME_OUT_W-1:0];
                            hit_cnt_next  = sat_inc(hit_cnt_reg);
                            upd_op_next   = UPD_PROMOTE;
                            state_next    = ST_UPDATE;
                            issue_next    = 1'b1;
                            idx_next      = '0;
                        end
                        else
                        begin
                            miss_cnt_next = sat_inc(miss_cnt_reg);
                        end
                    end
                    KIND_INSERT:
                    begin
                        upd_op_next = UPD_PROMOTE;
                        state_next  = ST_UPDATE;
                        issue_next  = 1'b1;
                        idx_next    = '0;
                        if (found_reg)
                        begin
                            wr_frame_next = 1'b1;
                        end
                        else
                        begin
                            wr_tags_next  = 1'b1;
                            tgt_rank_next = LAST_IDX;
                            if (free_found_reg)
                            begin
                                tgt_next = free_idx_reg;
                            end
                            else
                            begin
                                tgt_next       = victim_reg;
                                ev_next        = 1'b1;
                                evict_cnt_next = sat_inc(evict_cnt_reg);
                            end
                        end
                    end
                    KIND_INV_ENTRY, KIND_INV_PID, KIND_INV_FRAME:
                    begin
                        if (found_reg)
                        begin
                            upd_op_next = UPD_DROP;
                            state_next  = ST_UPDATE;
                            issue_next  = 1'b1;
                            idx_next    = '0;
                        end
                    end
                    KIND_CLEAR_STAT:
                    begin
                        hit_cnt_next   = '0;
                        miss_cnt_next  = '0;
                        evict_cnt_next = '0;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_UPDATE:
            begin
                if (dval_reg)
                begin
                    if (is_target)
                    begin
                        valid_next[didx_reg] = (upd_op_reg == UPD_PROMOTE);
                    end
                    if (didx_reg == LAST_IDX)
                    begin
                        case (item_reg.kind) inside
                            KIND_INV_PID, KIND_INV_FRAME:
                            begin
                                // look for the next entry to remove
                                state_next        = ST_MATCH;
                                issue_next        = 1'b1;
                                idx_next          = '0;
                                found_next        = 1'b0;
                                free_found_next   = 1'b0;
                                victim_found_next = 1'b0;
                            end
                            default:
                            begin
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_item_next.hit         = hit_flag_reg;
                    rsp_item_next.frame_out   = fout_reg;
                    rsp_item_next.evicted     = ev_reg;
                    rsp_item_next.hit_total   = hit_cnt_reg;
                    rsp_item_next.miss_total  = miss_cnt_reg;
                    rsp_item_next.evict_total = evict_cnt_reg;
                    rsp_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_reg        <= 1'b0;
            dval_reg         <= 1'b0;
            valid_reg        <= '0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            evict_cnt_reg    <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issue_reg        <= issue_next;
            dval_reg         <= dval_next;
            valid_reg        <= valid_next;
            found_reg        <= found_next;
            free_found_reg   <= free_found_next;
            victim_found_reg <= victim_found_next;
            hit_cnt_reg      <= hit_cnt_next;
            miss_cnt_reg     <= miss_cnt_next;
            evict_cnt_reg    <= evict_cnt_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        didx_reg      <= didx_next;
        tgt_reg       <= tgt_next;
        tgt_rank_reg  <= tgt_rank_next;
        tgt_frame_reg <= tgt_frame_next;
        free_idx_reg  <= free_idx_next;
        victim_reg    <= victim_next;
        upd_op_reg    <= upd_op_next;
        wr_tags_reg   <= wr_tags_next;
        wr_frame_reg  <= wr_frame_next;
        hit_flag_reg  <= hit_flag_next;
        fout_reg      <= fout_next;
        ev_reg        <= ev_next;
        rsp_item_reg  <= rsp_item_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // store writes happen only in the update pass
    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_UPDATE))
        else $error("entry store written outside the update pass");

    // scan data only arrives while a pass runs
    a_data_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        dval_reg |-> ((state_reg == ST_MATCH) || (state_reg == ST_UPDATE)))
        else $error("scan data outside a pass");

    // a full buffer always holds an oldest entry to evict
    a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DECIDE) && (item_reg.kind == KIND_INSERT)
         && !found_reg && !free_found_reg) |-> victim_found_reg)
        else $error("insert into full buffer without an oldest entry");

    // a finished result reaches the output register when it is free
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && !rsp_valid_reg) |=> rsp_valid_reg)
        else $error("result not loaded into a free output register");

    // no new request taken while a pass is running
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_reg || dval_reg) |-> !req_ready)
        else $error("request ready during a scan pass");

endmodule
